[rtl/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;
    localparam int unsigned DefEntries = 16;
    localparam int unsigned KeyW = 32;
    localparam int unsigned DataW = 32;
    localparam int unsigned CapW = 5;
    localparam logic [CapW-1:0] CapReset = 5'd16;
    localparam logic OpGet = 1'b0;
    localparam logic OpPut = 1'b1;
    localparam logic [DataW-1:0] MissValue = '1;

    typedef struct packed {
        logic             op;
        logic [KeyW-1:0]  key;
        logic [DataW-1:0] value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [DataW-1:0] read_value;
        logic             evicted;
    } rsp_t;
endpackage
`default_nettype wire

[rtl/lkvc_req_queue.sv]
// Request queue between the front end and the cache engine.
`default_nettype none
module lkvc_req_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  lkvc_pkg::req_t     wr_data,
    output logic               avail,
    input  wire logic          take,
    output lkvc_pkg::req_t     rd_data
);
    import lkvc_pkg::*;

    req_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign avail   = (count_reg != 2'd0);
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (take && avail)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push && !full} - {1'b0, take && avail};
        end
    end
endmodule
`default_nettype wire

[rtl/lkvc_engine.sv]
// Cache engine: associative lookup, age update, eviction and result register.
`default_nettype none
module lkvc_engine
#(
    parameter int unsigned ENTRIES = lkvc_pkg::DefEntries
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [lkvc_pkg::CapW-1:0] capacity,
    input  wire logic                    avail,
    output logic                         take,
    input  lkvc_pkg::req_t               req,
    output logic                         rsp_valid,
    input  wire logic                    rsp_take,
    output lkvc_pkg::rsp_t               rsp
);
    import lkvc_pkg::*;

    localparam int unsigned AgeW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [KeyW-1:0]    key_reg  [ENTRIES];
    logic [DataW-1:0]   data_reg [ENTRIES];
    logic [AgeW-1:0]    age_reg  [ENTRIES];
    logic [CntW-1:0]    used_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [ENTRIES-1:0] match, oldest_vec, free_first;
    logic               found, full_now, do_evict, do_ins;
    logic [DataW-1:0]   hit_data;
    logic [AgeW-1:0]    hit_age;
    logic [ENTRIES-1:0] ins_vec;
    logic [CntW-1:0]    eff_cap;
    logic               any_free;

    // accept when the result register is free or being drained
    assign take      = avail && (!rsp_valid_reg || rsp_take);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic seen;
        match    = '0;
        hit_data = '0;
        hit_age  = '0;
        oldest_vec = '0;
        free_first = '0;
        seen = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match[i])
            begin
                hit_data = hit_data | data_reg[i];
                hit_age  = hit_age | age_reg[i];
            end
            // the least recent valid entry holds rank used-1
            oldest_vec[i] = valid_reg[i] &&
                ({{(CntW-AgeW){1'b0}}, age_reg[i]} == used_reg - CntW'(1));
            if (!valid_reg[i] && !seen)
            begin
                free_first[i] = 1'b1;
                seen = 1'b1;
            end
        end
        any_free = seen;
        found = |match;
        if (capacity == '0)
            eff_cap = CntW'(1);
        else if (32'(capacity) > ENTRIES)
            eff_cap = CntW'(ENTRIES);
        else
            eff_cap = CntW'(capacity);
        full_now = (used_reg >= eff_cap) && (used_reg != '0);
        do_evict = (req.op == OpPut) && !found && full_now;
        do_ins   = (req.op == OpPut) && !found && (full_now || any_free);
        ins_vec  = do_evict ? oldest_vec : free_first;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (found && match[i] && req.op == OpPut)
                    data_reg[i] <= req.value;
                if (do_ins && ins_vec[i])
                begin
                    key_reg[i]  <= req.key;
                    data_reg[i] <= req.value;
                end
            end
            rsp_reg.hit        <= found;
            rsp_reg.evicted    <= do_evict;
            rsp_reg.read_value <= (req.op == OpPut) ? '0 : (found ? hit_data : MissValue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            if (rsp_take)
                rsp_valid_reg <= 1'b0;
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (found)
                    begin
                        if (match[i])
                            age_reg[i] <= '0;
                        else if (valid_reg[i] && age_reg[i] < hit_age)
                            age_reg[i] <= age_reg[i] + AgeW'(1);
                    end
                    else if (do_ins)
                    begin
                        if (ins_vec[i])
                        begin
                            age_reg[i]   <= '0;
                            valid_reg[i] <= 1'b1;
                        end
                        else if (valid_reg[i])
                            age_reg[i] <= age_reg[i] + AgeW'(1);
                    end
                end
                if (do_ins && !do_evict)
                    used_reg <= used_reg + CntW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/lru_key_value_cache.sv]
// Top level of the LRU key/value cache.
// A request passes through the request queue and then the engine's result
// register before it is answered.
// Throughput: one request per cycle while results are popped, set by the
// associative compare and age update in the engine.
// Reset: all entries invalid, capacity 16, request queue and result register empty.
`default_nettype none
module lru_key_value_cache
#(
    parameter int unsigned ENTRIES = lkvc_pkg::DefEntries
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        opcode,
    input  wire logic signed [31:0]          key,
    input  wire logic signed [31:0]          value,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             hit,
    output logic signed [31:0]               read_value,
    output logic                             evicted,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lkvc_pkg::CapW-1:0]   cfg_data
);
    import lkvc_pkg::*;

    logic [CapW-1:0] capacity_reg;
    req_t in_req, q_req;
    rsp_t rsp;
    logic avail, take, rsp_valid;

    assign cfg_ready = 1'b1;
    assign in_req    = '{op: opcode, key: key, value: value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CapReset;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    lkvc_req_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .wr_data(in_req),
        .avail(avail), .take(take), .rd_data(q_req)
    );

    lkvc_engine #(.ENTRIES(ENTRIES)) u_engine
    (
        .clk(clk), .rst_n(rst_n), .capacity(capacity_reg), .avail(avail),
        .take(take), .req(q_req), .rsp_valid(rsp_valid), .rsp_take(pop),
        .rsp(rsp)
    );

    assign empty      = !rsp_valid;
    assign hit        = rsp.hit;
    assign read_value = rsp.read_value;
    assign evicted    = rsp.evicted;

    a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && evicted |-> !hit)
        else $error("eviction reported on a hit");
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !hit && !evicted && read_value != '1 |-> read_value == '0)
        else $error("unexpected read value");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(read_value))
        else $error("result dropped while stalled");
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the LRU key/value cache.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    localparam int NumSlots = 16;
    localparam int IdleLimit = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic opcode = OpGet;
    logic signed [31:0] key = '0;
    logic signed [31:0] value = '0;
    logic empty;
    logic pop = 1'b0;
    logic hit;
    logic signed [31:0] read_value;
    logic evicted;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CapW-1:0] cfg_data = '0;

    lru_key_value_cache uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .key(key), .value(value), .empty(empty), .pop(pop), .hit(hit),
        .read_value(read_value), .evicted(evicted), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cache mirror
    logic            slot_valid [NumSlots];
    logic [31:0]     slot_key [NumSlots];
    logic [31:0]     slot_data [NumSlots];
    int unsigned     slot_age [NumSlots];
    int unsigned     used_count;
    logic [CapW-1:0] cap_reg;

    rsp_t            pending_rsp [$];
    logic [31:0]     known_keys [$];
    int              error_count = 0;
    int              idle_cycles = 0;
    int              burst_left = 0;

    function automatic void mirror_reset();
        for (int i = 0; i < NumSlots; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_data[i] = '0;
            slot_age[i] = 0;
        end
        used_count = 0;
        cap_reg = CapReset;
    endfunction

    function automatic void make_newest(int idx);
        int unsigned a;
        a = slot_age[idx];
        for (int j = 0; j < NumSlots; j++)
            if (slot_valid[j] && slot_age[j] < a)
                slot_age[j]++;
        slot_age[idx] = 0;
    endfunction

    function automatic rsp_t cache_lookup(logic op, logic [31:0] k, logic [31:0] v);
        rsp_t r;
        int found;
        int slot;
        int oldest;
        int unsigned eff;
        r = '0;
        found = -1;
        slot = -1;
        oldest = -1;
        for (int i = 0; i < NumSlots; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;
        if (op == OpGet)
        begin
            if (found >= 0)
            begin
                r.hit = 1'b1;
                r.read_value = slot_data[found];
                make_newest(found);
            end
            else
                r.read_value = MissValue;
        end
        else if (found >= 0)
        begin
            r.hit = 1'b1;
            slot_data[found] = v;
            make_newest(found);
        end
        else
        begin
            eff = (cap_reg == 0) ? 1 : ((cap_reg > NumSlots) ? NumSlots : cap_reg);
            if (used_count >= eff && used_count > 0)
            begin
                for (int j = 0; j < NumSlots; j++)
                    if (slot_valid[j] && (oldest < 0 || slot_age[j] > slot_age[oldest]))
                        oldest = j;
                if (oldest >= 0)
                begin
                    slot_valid[oldest] = 1'b0;
                    used_count--;
                    slot = oldest;
                    r.evicted = 1'b1;
                end
            end
            if (slot < 0)
                for (int j = NumSlots - 1; j >= 0; j--)
                    if (!slot_valid[j])
                        slot = j;
            if (slot >= 0)
            begin
                for (int j = 0; j < NumSlots; j++)
                    if (slot_valid[j])
                        slot_age[j]++;
                slot_valid[slot] = 1'b1;
                slot_key[slot] = k;
                slot_data[slot] = v;
                slot_age[slot] = 0;
                used_count++;
            end
        end
        return r;
    endfunction

    // compare each popped transaction with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && pop && !empty)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (hit !== exp_rsp.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_rsp.hit, hit);
                    error_count++;
                end
                if (read_value !== exp_rsp.read_value)
                begin
                    $error("read_value: expected %h, got %h", exp_rsp.read_value, read_value);
                    error_count++;
                end
                if (evicted !== exp_rsp.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", exp_rsp.evicted, evicted);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls: alternate calm and heavy stretches
    always @(negedge clk)
    begin
        int phase;
        phase = int'(($time / 20000) % 3);
        if (phase == 0)
            pop <= 1'b1;
        else if (phase == 1)
            pop <= ($urandom_range(3) != 0);
        else
            pop <= ($urandom_range(3) == 0);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // push stays high between back-to-back transactions; drop it for gaps
    task automatic send_req(logic op, logic [31:0] k, logic [31:0] v);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(1) == 1)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        opcode <= op;
        key <= k;
        value <= v;
        do
            @(posedge clk);
        while (full);
        pending_rsp.push_back(cache_lookup(op, k, v));
        if (op == OpPut)
            known_keys.push_back(k);
        if (known_keys.size() > 40)
            void'(known_keys.pop_front());
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CapW-1:0] c);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = c;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_req(OpGet, 32'h8000_0000, 32'h0);
        send_req(OpPut, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(OpPut, 32'h7FFF_FFFF, 32'h8000_0000);
        send_req(OpPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(OpPut, 32'h0, 32'h0);
        send_req(OpGet, 32'h8000_0000, 32'h1234);
        send_req(OpGet, 32'h7FFF_FFFF, 32'h0);
        send_req(OpGet, 32'hFFFF_FFFF, 32'h0);
        send_req(OpPut, 32'h0, 32'h5555_AAAA);
        send_req(OpGet, 32'h0, 32'h0);
        send_req(OpGet, 32'h1, 32'h0);
    endtask

    // capacity 1, zero and above the built size, then a lowered capacity
    task automatic test_capacity_edges();
        write_capacity(5'd1);
        send_req(OpPut, 32'd10, 32'd100);
        send_req(OpPut, 32'd11, 32'd110);
        send_req(OpGet, 32'd10, 32'd0);
        write_capacity(5'd0);
        send_req(OpPut, 32'd12, 32'd120);
        send_req(OpGet, 32'd11, 32'd0);
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_req(OpPut, 32'd200 + i, $urandom);
        write_capacity(5'd4);
        send_req(OpPut, 32'd300, 32'd3);
        send_req(OpGet, 32'd205, 32'd0);
        send_req(OpPut, 32'd210, 32'd9);
    endtask

    task automatic test_random(int count, int key_span);
        logic [31:0] k;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
                k = $urandom;
            else if (known_keys.size() != 0 && $urandom_range(1) == 1)
                k = known_keys[$urandom_range(known_keys.size() - 1)];
            else
                k = $urandom_range(key_span) ^ {($urandom_range(1) == 1), 31'h0};
            send_req(1'($urandom_range(1)), k, $urandom);
        end
    endtask

    initial
    begin
        mirror_reset();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_capacity_edges();
        write_capacity(5'd16);
        test_random(500, 40);
        write_capacity(5'd3);
        test_random(350, 10);
        write_capacity(5'd8);
        test_random(350, 24);
        write_capacity(5'd1);
        test_random(150, 4);
        write_capacity(5'd20);
        test_random(450, 30);
        drain();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
